// File: hw/rtl/sps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// shared types and constants of the substring position search block
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 16;
    localparam int POS_W     = 17;
    localparam int PLEN_W    = 5;
    localparam int PAT_BYTES = 16;
    localparam int CFG_W     = 64;
    localparam int ADDR_W    = 5;
    localparam int REGIDX_W  = 2;

    typedef enum logic [REGIDX_W-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2,
        REG_SEARCH_START   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              byte_present;
        logic              end_of_text;
    } t_in_item;

    typedef struct packed {
        logic             match_found;
        logic [POS_W-1:0] match_position;
    } t_out_item;

endpackage

// File: hw/rtl/sps_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_in_if
// request channel carrying at most one text byte per request
// ----------------------------------------------------------------------------
interface sps_in_if;
    logic              valid;
    logic              ready;
    sps_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/sps_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_out_if
// result channel carrying the found flag and first match position
// ----------------------------------------------------------------------------
interface sps_out_if;
    logic               valid;
    logic               ready;
    sps_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/substring_position_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_position_search_top
// first position of a pattern of up to 16 bytes in a streamed text
// flow: an accepted request goes into the input register, and its result
//   into the output register (the end_of_text request only gives a result)
// throughput: one request per cycle unless the result stalls, set by the single
//   window compare and position update stage between input and result register
// reset: synchronous active-low; clears the pipeline, the stream state and
//   the registers (the search start returns to 1)
// ----------------------------------------------------------------------------
module substring_position_search_top #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sps_in_if.sink                      i_text,
    sps_out_if.source                   o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sps_pkg::ADDR_W-1:0]  paddr,
    input  logic [sps_pkg::CFG_W-1:0]   pwdata,
    output logic [sps_pkg::CFG_W-1:0]   prdata,
    output logic                        pready
);

    // widths that follow from the window depth
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CMP_W = (LEN_W > sps_pkg::PLEN_W) ? LEN_W : sps_pkg::PLEN_W;
    localparam int COUNT_W = sps_pkg::COUNT_W;
    localparam int POS_W   = sps_pkg::POS_W;
    localparam int BYTE_W  = sps_pkg::BYTE_W;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = {COUNT_W{1'b1}};

    // ------------------------------------------------------------------
    // configuration registers, 64-bit apb port, register i at byte 8*i
    // ------------------------------------------------------------------
    logic [sps_pkg::CFG_W-1:0]  r_pat_low;
    logic [sps_pkg::CFG_W-1:0]  r_pat_high;
    logic [sps_pkg::PLEN_W-1:0] r_pat_len;
    logic [COUNT_W-1:0]         r_start;
    sps_pkg::t_reg_idx          cfg_idx;
    logic                       cfg_wr;

    assign cfg_idx = sps_pkg::t_reg_idx'(paddr[sps_pkg::ADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
            r_start    <= COUNT_W'(1);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                sps_pkg::REG_PATTERN_LOW:    r_pat_low  <= pwdata;
                sps_pkg::REG_PATTERN_HIGH:   r_pat_high <= pwdata;
                sps_pkg::REG_PATTERN_LENGTH: r_pat_len  <= pwdata[sps_pkg::PLEN_W-1:0];
                sps_pkg::REG_SEARCH_START:   r_start    <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (cfg_idx)
            sps_pkg::REG_PATTERN_LOW:    prdata = r_pat_low;
            sps_pkg::REG_PATTERN_HIGH:   prdata = r_pat_high;
            sps_pkg::REG_PATTERN_LENGTH: prdata = sps_pkg::CFG_W'(r_pat_len);
            sps_pkg::REG_SEARCH_START:   prdata = sps_pkg::CFG_W'(r_start);
            default:                     prdata = '0;
        endcase
    end

    // pattern bytes as an array; bytes past the two registers read as zero
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_b;
    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_pat
        if (g < 8) begin : g_low
            assign pat_b[g] = r_pat_low[g*BYTE_W +: BYTE_W];
        end else if (g < sps_pkg::PAT_BYTES) begin : g_high
            assign pat_b[g] = r_pat_high[(g-8)*BYTE_W +: BYTE_W];
        end else begin : g_zero
            assign pat_b[g] = '0;
        end
    end

    // effective pattern length, saturated at the window depth
    logic [CMP_W-1:0] len_ext;
    logic [LEN_W-1:0] len_eff;
    logic [COUNT_W-1:0] start_eff;

    assign len_ext   = CMP_W'(r_pat_len);
    assign len_eff   = (len_ext > CMP_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                       : LEN_W'(len_ext);
    // a start of zero would point before the string
    assign start_eff = (r_start == '0) ? COUNT_W'(1) : r_start;

    // ------------------------------------------------------------------
    // handshake: input register, then the result register
    // ------------------------------------------------------------------
    logic              r_s1_vld;
    sps_pkg::t_in_item r_s1_item;
    logic              r_out_vld;
    sps_pkg::t_out_item r_out_item;
    logic              out_free;
    logic              s1_fire;
    logic              in_fire;

    assign out_free     = !r_out_vld || o_result.ready;
    assign s1_fire      = r_s1_vld && out_free;
    assign i_text.ready = !r_s1_vld || out_free;
    assign in_fire      = i_text.valid && i_text.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_fire) begin
            r_s1_vld <= 1'b1;
        end else if (s1_fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_text.data;
        end
    end

    // ------------------------------------------------------------------
    // stream state: window of recent bytes (entry 0 newest), count, hit
    // ------------------------------------------------------------------
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] r_win;
    logic [COUNT_W-1:0]                 r_seen;
    logic                               r_hit_vld;
    logic [COUNT_W-1:0]                 r_hit_pos;
    logic                               r_final_hit;

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] n_win;
    logic [COUNT_W-1:0]                 n_seen;
    logic                               n_hit_vld;
    logic [COUNT_W-1:0]                 n_hit_pos;
    logic                               n_final_hit;
    logic                               win_match;
    logic [COUNT_W-1:0]                 hit_pos;
    sps_pkg::t_out_item                 n_result;

    // window compare: pattern byte i against window entry len-1-i
    always_comb begin
        logic [LEN_W-1:0] idx;
        win_match = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            idx = len_eff - LEN_W'(1) - LEN_W'(i);
            if (LEN_W'(i) < len_eff) begin
                if (n_win[idx[IDX_W-1:0]] != pat_b[i]) begin
                    win_match = 1'b0;
                end
            end
        end
    end

    // byte update, then the end-of-text decision on the updated state
    always_comb begin
        n_win       = r_win;
        n_seen      = r_seen;
        n_hit_vld   = r_hit_vld;
        n_hit_pos   = r_hit_pos;
        n_final_hit = r_final_hit;
        hit_pos     = r_seen + COUNT_W'(1) - COUNT_W'(len_eff) + COUNT_W'(1);

        if (r_s1_item.byte_present) begin
            if (r_seen != COUNT_LIMIT) begin
                for (int k = PATTERN_MAX - 1; k > 0; k--) begin
                    n_win[k] = r_win[k-1];
                end
                n_win[0]    = r_s1_item.text_byte;
                n_seen      = r_seen + COUNT_W'(1);
                n_final_hit = 1'b0;
                if ((len_eff != '0) && (n_seen >= COUNT_W'(len_eff)) && win_match) begin
                    // first match at or after the start is kept
                    if (!r_hit_vld && (hit_pos >= start_eff)) begin
                        n_hit_vld = 1'b1;
                        n_hit_pos = hit_pos;
                    end
                    if (len_eff == LEN_W'(1)) begin
                        n_final_hit = 1'b1;
                    end
                end
            end else begin
                // counter saturated: byte ignored
                n_final_hit = 1'b0;
            end
        end

        // result: empty pattern, held hit, or start clamped to the last byte
        n_result.match_found    = 1'b0;
        n_result.match_position = '0;
        if (len_eff == '0) begin
            n_result.match_found    = 1'b1;
            n_result.match_position = POS_W'(n_seen) + POS_W'(1);
        end else if (n_hit_vld) begin
            n_result.match_found    = 1'b1;
            n_result.match_position = POS_W'(n_hit_pos);
        end else if ((start_eff > n_seen) && n_final_hit) begin
            n_result.match_found    = 1'b1;
            n_result.match_position = POS_W'(n_seen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= '0;
            r_seen      <= '0;
            r_hit_vld   <= 1'b0;
            r_hit_pos   <= '0;
            r_final_hit <= 1'b0;
        end else if (s1_fire) begin
            if (r_s1_item.end_of_text) begin
                // stream state starts over for the next string
                r_win       <= '0;
                r_seen      <= '0;
                r_hit_vld   <= 1'b0;
                r_hit_pos   <= '0;
                r_final_hit <= 1'b0;
            end else begin
                r_win       <= n_win;
                r_seen      <= n_seen;
                r_hit_vld   <= n_hit_vld;
                r_hit_pos   <= n_hit_pos;
                r_final_hit <= n_final_hit;
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= s1_fire && r_s1_item.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_item.end_of_text) begin
            r_out_item <= n_result;
        end
    end

    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out_item;

endmodule

// File: hw/rtl/sps_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_check
// port-level checks of the substring position search block
// ----------------------------------------------------------------------------
module sps_check (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_out_found,
    input logic [sps_pkg::POS_W-1:0] i_out_pos
);

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_found)
            && $stable(i_out_pos))
        else $error("result changed while stalled");

    // no match means position zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_pos == '0)
        else $error("miss with nonzero position");

    // a match is always at a 1-based position
    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_found |-> i_out_pos != '0)
        else $error("hit at position zero");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result present after reset");

endmodule

bind substring_position_search_top sps_check u_sps_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_found (o_result.data.match_found),
    .i_out_pos   (o_result.data.match_position)
);
